FILE: rtl/core/mckc_pkg.sv
`timescale 1ns / 1ps

package mckc_pkg;

  // Field and register widths
  localparam int CfgW    = 8;
  localparam int CfgIdxW = 2;
  localparam int ActW    = 3;
  localparam int PhaseW  = 4;
  localparam int DebW    = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_LONG    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVALID = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAP     = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 2'd3;

  // Reset values of the configuration registers
  localparam logic [CfgW-1:0] LONG_RST     = 8'd20;
  localparam logic [CfgW-1:0] INVALID_RST  = 8'd10;
  localparam logic [CfgW-1:0] GAP_RST      = 8'd5;
  localparam logic [CfgW-1:0] DEBOUNCE_RST = 8'd1;

  // Action codes
  localparam logic [ActW-1:0] ACT_INVALID = 3'd0;
  localparam logic [ActW-1:0] ACT_SINGLE  = 3'd1;
  localparam logic [ActW-1:0] ACT_DOUBLE  = 3'd2;
  localparam logic [ActW-1:0] ACT_TRIPLE  = 3'd3;
  localparam logic [ActW-1:0] ACT_LONG    = 3'd4;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE  = 4'd0;
  localparam logic [PhaseW-1:0] PH_DEB1  = 4'd1;
  localparam logic [PhaseW-1:0] PH_HOLD1 = 4'd2;
  localparam logic [PhaseW-1:0] PH_GAP1  = 4'd3;
  localparam logic [PhaseW-1:0] PH_DEB2  = 4'd4;
  localparam logic [PhaseW-1:0] PH_HOLD2 = 4'd5;
  localparam logic [PhaseW-1:0] PH_GAP2  = 4'd6;
  localparam logic [PhaseW-1:0] PH_DEB3  = 4'd7;
  localparam logic [PhaseW-1:0] PH_HOLD3 = 4'd8;

  typedef struct packed {
    logic [CfgW-1:0] long_press_ticks;
    logic [CfgW-1:0] invalid_press_ticks;
    logic [CfgW-1:0] click_gap_ticks;
    logic [CfgW-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic key_pressed;
    logic tick;
  } item_t;

  // Core status toward the top level
  typedef struct packed {
    logic fire;   // held item consumed this cycle
    logic emit;   // that item produced a result
    logic idle;   // phase register is idle
  } core_st_t;

endpackage

FILE: rtl/core/mckc_ifs.sv
`timescale 1ns / 1ps

interface mckc_in_if;
  logic valid;
  logic ready;
  logic key_pressed;
  logic tick;

  modport source (output valid, output key_pressed, output tick, input ready);
  modport sink (input valid, input key_pressed, input tick, output ready);
endinterface

interface mckc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action_code;

  modport source (output valid, output action_code, input ready);
  modport sink (input valid, input action_code, output ready);
endinterface

FILE: rtl/core/multi_click_key_classifier.sv
`timescale 1ns / 1ps

// Key click classifier: turns a stream of sampled key levels into click events.
//
// key_i  : one transfer per sample, carrying key_pressed (1 = down) and tick
//          (1 = one time unit elapsed with this sample).
// act_o  : one transfer per decision, action_code 0 invalid, 1 single,
//          2 double, 3 triple, 4 long press. Most samples produce nothing.
// cfg_*  : write port for the four 8-bit thresholds (index 0 long press,
//          1 invalid press, 2 click gap, 3 debounce). Write only while idle.
//
// Path: a sample is held in the input register, is evaluated against the
// phase, timer and debounce counter, and a resulting code is loaded into the
// result register, from which it is visible on act_o.
// Throughput: one sample per cycle unless act_o stalls, set by the single-pass
// phase register update; the input register refills in the cycle it is consumed.
// Reset: phase idle, timers zero, thresholds 20/10/5/1, both stages empty.
// Stall: while act_o holds an untaken code, hold the next sample in the
// input register unevaluated; key_i ready drops once that register is full.

module multi_click_key_classifier #(
  parameter int TIMER_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mckc_in_if.sink                      key_i,
  mckc_out_if.source                   act_o,
  input  logic                         cfg_we_i,
  input  logic [mckc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mckc_pkg::CfgW-1:0]    cfg_data_i
);
  import mckc_pkg::*;

  cfg_t     cfg;
  item_t    item;
  logic     item_valid;
  core_st_t core_st;

  // Threshold registers
  mckc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Input register; refills in the same cycle the core consumes it
  mckc_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .key_i   (key_i),
    .fire_i  (core_st.fire),
    .valid_o (item_valid),
    .item_o  (item)
  );

  // Phase machine, timers and result register
  mckc_core #(
    .TimerWidth (TIMER_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (item_valid),
    .item_i  (item),
    .act_o   (act_o),
    .st_o    (core_st)
  );

  // A new code appears only from a sample consumed in the previous cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(act_o.valid) |-> $past(core_st.fire))
    else $error("result appeared without a consumed sample");

  // Every decision sends the phase machine back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    core_st.fire && core_st.emit |=> core_st.idle)
    else $error("phase not idle after a decision");

  // A stalled result blocks evaluation of the next sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_o.valid && !act_o.ready |-> !core_st.fire)
    else $error("sample consumed over a stalled result");

endmodule

FILE: rtl/core/mckc_cfg_regs.sv
`timescale 1ns / 1ps

module mckc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [mckc_pkg::CfgIdxW-1:0] idx_i,
  input  logic [mckc_pkg::CfgW-1:0]    data_i,
  output mckc_pkg::cfg_t               cfg_o
);
  import mckc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_LONG:     cfg_d.long_press_ticks    = data_i;
        CFG_INVALID:  cfg_d.invalid_press_ticks = data_i;
        CFG_GAP:      cfg_d.click_gap_ticks     = data_i;
        CFG_DEBOUNCE: cfg_d.debounce_ticks      = data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press_ticks    <= LONG_RST;
      cfg_q.invalid_press_ticks <= INVALID_RST;
      cfg_q.click_gap_ticks     <= GAP_RST;
      cfg_q.debounce_ticks      <= DEBOUNCE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/mckc_in_stage.sv
`timescale 1ns / 1ps

module mckc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  mckc_in_if.sink         key_i,
  input  logic            fire_i,
  output logic            valid_o,
  output mckc_pkg::item_t item_o
);
  import mckc_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  take;

  // Refill when empty or when the held item leaves this cycle
  assign key_i.ready = !valid_q || fire_i;
  assign take        = key_i.valid && key_i.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d            = 1'b1;
      item_d.key_pressed = key_i.key_pressed;
      item_d.tick        = key_i.tick;
    end else if (fire_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/core/mckc_core.sv
`timescale 1ns / 1ps

module mckc_core #(
  parameter int TimerWidth = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mckc_pkg::cfg_t     cfg_i,
  input  logic               valid_i,
  input  mckc_pkg::item_t    item_i,
  mckc_out_if.source         act_o,
  output mckc_pkg::core_st_t st_o
);
  import mckc_pkg::*;

  localparam int CmpW = (TimerWidth > CfgW) ? TimerWidth : CfgW;

  logic [PhaseW-1:0]     phase_q, phase_d;
  logic [TimerWidth-1:0] el_q, el_d, el_t;
  logic [DebW-1:0]       db_q, db_d, db_t;
  logic                  out_valid_q, out_valid_d;
  logic [ActW-1:0]       act_q, act_d;
  logic                  fire, emit;
  logic [ActW-1:0]       code;
  logic                  settled, gt_long, gt_inv, gt_gap;
  logic                  key, tick;

  assign key  = item_i.key_pressed;
  assign tick = item_i.tick;
  assign fire = valid_i && (!out_valid_q || act_o.ready);

  // Saturating advance on a tick
  assign el_t = (tick && (el_q != {TimerWidth{1'b1}})) ? el_q + TimerWidth'(1) : el_q;
  assign db_t = (tick && (db_q != {DebW{1'b1}})) ? db_q + DebW'(1) : db_q;

  assign settled = db_t >= cfg_i.debounce_ticks;
  assign gt_long = CmpW'(el_t) > CmpW'(cfg_i.long_press_ticks);
  assign gt_inv  = CmpW'(el_t) > CmpW'(cfg_i.invalid_press_ticks);
  assign gt_gap  = CmpW'(el_t) > CmpW'(cfg_i.click_gap_ticks);

  always_comb begin
    phase_d = phase_q;
    el_d    = el_q;
    db_d    = db_q;
    emit    = 1'b0;
    code    = ACT_INVALID;
    if (phase_q == PH_IDLE) begin
      if (key) begin
        el_d    = '0;
        db_d    = '0;
        phase_d = PH_DEB1;
      end
    end else begin
      el_d = el_t;
      db_d = db_t;
      unique case (phase_q)
        PH_DEB1: begin
          if (settled) phase_d = key ? PH_HOLD1 : PH_IDLE;
        end
        PH_HOLD1: begin
          if (key) begin
            if (gt_long) begin
              emit = 1'b1;
              code = ACT_LONG;
            end
          end else if (gt_inv) begin
            emit = 1'b1;
            code = ACT_INVALID;
          end else if (gt_gap) begin
            emit = 1'b1;
            code = ACT_SINGLE;
          end else begin
            phase_d = PH_GAP1;
          end
        end
        PH_GAP1: begin
          if (key) begin
            db_d    = '0;
            phase_d = PH_DEB2;
          end else if (gt_gap) begin
            emit = 1'b1;
            code = ACT_SINGLE;
          end
        end
        PH_DEB2: begin
          if (settled) begin
            if (key) begin
              el_d    = '0;
              phase_d = PH_HOLD2;
            end else if (gt_gap) begin
              emit = 1'b1;
              code = ACT_SINGLE;
            end else begin
              phase_d = PH_GAP1;
            end
          end
        end
        PH_HOLD2: begin
          if (key) begin
            if (gt_gap) begin
              emit = 1'b1;
              code = ACT_INVALID;
            end
          end else begin
            el_d    = '0;
            phase_d = PH_GAP2;
          end
        end
        PH_GAP2: begin
          if (key) begin
            db_d    = '0;
            phase_d = PH_DEB3;
          end else if (gt_gap) begin
            emit = 1'b1;
            code = ACT_DOUBLE;
          end
        end
        PH_DEB3: begin
          if (settled) begin
            if (key) begin
              el_d    = '0;
              phase_d = PH_HOLD3;
            end else if (gt_gap) begin
              emit = 1'b1;
              code = ACT_DOUBLE;
            end else begin
              phase_d = PH_GAP2;
            end
          end
        end
        PH_HOLD3: begin
          if (!key || gt_gap) begin
            emit = 1'b1;
            code = ACT_TRIPLE;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
      if (emit) phase_d = PH_IDLE;
    end
  end

  // Result register: load on fire, drop once the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    act_d       = act_q;
    if (fire) begin
      out_valid_d = emit;
      act_d       = code;
    end else if (act_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      el_q        <= '0;
      db_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q <= phase_d;
        el_q    <= el_d;
        db_q    <= db_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q <= act_d;
  end

  assign act_o.valid       = out_valid_q;
  assign act_o.action_code = act_q;

  assign st_o.fire = fire;
  assign st_o.emit = emit;
  assign st_o.idle = (phase_q == PH_IDLE);

endmodule
